// ===== design/hmd_pkg.sv =====
package hmd_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 15;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 15;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned TE_W   = 9;
  localparam int unsigned CNT_W  = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic REG_TABLE_ENTRIES    = 1'b0;
  localparam logic REG_SYMBOLS_EXPECTED = 1'b1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [7:0]        entry_index;
    logic [SYM_W-1:0]  entry_symbol;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic [7:0]        data_byte;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             finished;
    logic             code_error;
  } out_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

// ===== design/hmd_stream_if.sv =====
interface hmd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/huffman_table_match_decoder.sv =====
// Huffman table match decoder. A load word (operation 0) writes one code table slot and gives
// no result; a decode word (operation 1) shifts its byte MSB first into the prefix, one bit
// per cycle while the result register is free, and each bit is matched in that cycle against
// every enabled slot of a row of table cells, the lowest matching slot winning through the
// cell chain. Words are taken only while idle: a decode word runs its 8 bit steps and flushes
// the last result first, its steps ending early when a symbol finishes decoding within the
// byte and skipped once decoding has finished; a load word leaves the decoder idle.
// Set table_entries (0x0) and symbols_expected (0x4) over APB only while idle. Table slots
// read before they are written give undefined symbols.
module huffman_table_match_decoder #(
  parameter int unsigned TABLE_DEPTH  = hmd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CODE_LEN = hmd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hmd_stream_if.sink   in_s,
  hmd_stream_if.source out_s,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned PW = MAX_CODE_LEN;
  localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);

  logic [1:0]                    state_r, state_nxt;
  logic [hmd_pkg::TE_W-1:0]      te_r;
  logic [hmd_pkg::CNT_W-1:0]     se_r;
  logic [PW-1:0]                 prefix_r, prefix_nxt;
  logic [LW-1:0]                 plen_r, plen_nxt;
  logic [hmd_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          done_r, done_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic [2:0]                    bit_r, bit_nxt;
  logic                          pend_v_r, pend_v_nxt;
  hmd_pkg::out_word_t            pend_r, pend_nxt;
  logic                          out_v_r, out_v_nxt;
  hmd_pkg::out_word_t            out_r, out_nxt;

  logic                          in_acc, load_acc, out_free, cfg_wr;
  logic [PW-1:0]                 nb;
  logic [LW-1:0]                 nlen;
  logic [TABLE_DEPTH:0]          hit_c;
  logic [hmd_pkg::SYM_W-1:0]     sym_c [TABLE_DEPTH+1];
  logic                          hit, err, fin;
  logic [hmd_pkg::CNT_W-1:0]     count_inc;
  hmd_pkg::entry_t               wentry;

  assign in_s.ready  = (state_r == hmd_pkg::ST_IDLE);
  assign in_acc      = in_s.valid && in_s.ready;
  assign load_acc    = in_acc && (in_s.data.operation == hmd_pkg::OP_LOAD);
  assign out_free    = !out_v_r || out_s.ready;
  assign out_s.valid = out_v_r;
  assign out_s.data  = out_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == hmd_pkg::REG_SYMBOLS_EXPECTED) ? se_r
                                                              : 32'(te_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_r <= '0;
      se_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hmd_pkg::REG_TABLE_ENTRIES:    te_r <= pwdata[hmd_pkg::TE_W-1:0];
        hmd_pkg::REG_SYMBOLS_EXPECTED: se_r <= pwdata;
        default: ;
      endcase
    end
  end

  assign wentry.sym  = in_s.data.entry_symbol;
  assign wentry.code = in_s.data.entry_code;
  assign wentry.len  = in_s.data.entry_length;

  assign nb   = {prefix_r[PW-2:0], byte_r[7]};
  assign nlen = plen_r + LW'(1);

  assign hit_c[TABLE_DEPTH] = 1'b0;
  assign sym_c[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hmd_cell #(.PW(PW), .LW(LW)) u_cell (
      .clk     (clk),
      .we      (load_acc && (9'(in_s.data.entry_index) == 9'(i))),
      .wdata   (wentry),
      .enable  (9'(i) < te_r),
      .prefix  (nb),
      .plen    (nlen),
      .hit_in  (hit_c[i+1]),
      .sym_in  (sym_c[i+1]),
      .hit_out (hit_c[i]),
      .sym_out (sym_c[i])
    );
  end

  assign hit       = hit_c[0];
  assign err       = !hit && (nlen == LW'(MAX_CODE_LEN));
  assign count_inc = count_r + 32'd1;
  assign fin       = hit && (se_r != '0) && (count_inc == se_r);

  always_comb begin
    state_nxt  = state_r;
    prefix_nxt = prefix_r;
    plen_nxt   = plen_r;
    count_nxt  = count_r;
    done_nxt   = done_r;
    byte_nxt   = byte_r;
    bit_nxt    = bit_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_s.ready;
    out_nxt    = out_r;
    unique case (state_r)
      hmd_pkg::ST_IDLE: begin
        if (in_acc && (in_s.data.operation == hmd_pkg::OP_DECODE)) begin
          byte_nxt  = in_s.data.data_byte;
          bit_nxt   = '0;
          state_nxt = done_r ? hmd_pkg::ST_FLUSH : hmd_pkg::ST_RUN;
        end
      end
      hmd_pkg::ST_RUN: begin
        if (out_free) begin
          if (hit || err) begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_v_nxt          = 1'b1;
            pend_nxt.symbol     = hit ? sym_c[0] : '0;
            pend_nxt.last       = 1'b0;
            pend_nxt.finished   = fin;
            pend_nxt.code_error = err;
            prefix_nxt          = '0;
            plen_nxt            = '0;
          end else begin
            prefix_nxt = nb;
            plen_nxt   = nlen;
          end
          if (hit) begin
            count_nxt = count_inc;
          end
          byte_nxt = {byte_r[6:0], 1'b0};
          bit_nxt  = bit_r + 3'd1;
          if (fin) begin
            done_nxt = 1'b1;
          end
          if (fin || (bit_r == 3'd7)) begin
            state_nxt = hmd_pkg::ST_FLUSH;
          end
        end
      end
      hmd_pkg::ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = hmd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = hmd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hmd_pkg::ST_IDLE;
      prefix_r <= '0;
      plen_r   <= '0;
      count_r  <= '0;
      done_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      plen_r   <= plen_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bit_r  <= bit_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  a_plen_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r < LW'(MAX_CODE_LEN))
    else $error("prefix length reached maximum without clearing");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done flag dropped");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hmd_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("pending result left behind in idle");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.code_error) |-> ((out_r.symbol == '0) && !out_r.finished))
    else $error("malformed error word");

endmodule

// ===== design/hmd_cell.sv =====
module hmd_cell #(
  parameter int unsigned PW = hmd_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned LW = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  hmd_pkg::entry_t           wdata,
  input  logic                      enable,
  input  logic [PW-1:0]             prefix,
  input  logic [LW-1:0]             plen,
  input  logic                      hit_in,
  input  logic [hmd_pkg::SYM_W-1:0] sym_in,
  output logic                      hit_out,
  output logic [hmd_pkg::SYM_W-1:0] sym_out
);

  localparam int unsigned CW = (hmd_pkg::CODE_W > PW) ? hmd_pkg::CODE_W : PW;
  localparam int unsigned MW = (hmd_pkg::LEN_W > LW) ? hmd_pkg::LEN_W : LW;

  hmd_pkg::entry_t           entry_r;
  logic [hmd_pkg::CODE_W-1:0] masked;
  logic                      match;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= wdata;
    end
  end

  assign masked = entry_r.code & ~({hmd_pkg::CODE_W{1'b1}} << entry_r.len);
  assign match  = enable && (entry_r.len != '0)
                  && (MW'(entry_r.len) == MW'(plen))
                  && (CW'(masked) == CW'(prefix));

  assign hit_out = match | hit_in;
  assign sym_out = match ? entry_r.sym : sym_in;

endmodule
